>>> hw/rtl/radar_sweep_pixel_shader_defines.svh
// ============================================================================
// Radar sweep pixel shader assertion macros
// Shared concurrent assertion forms for the checker files.
// ============================================================================
`ifndef RADAR_SWEEP_PIXEL_SHADER_DEFINES_SVH
`define RADAR_SWEEP_PIXEL_SHADER_DEFINES_SVH

// property checked only outside reset
`define RSPS_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property checked at every edge, reset included
`define RSPS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hw/rtl/rsps_pkg.sv
// ============================================================================
// Radar sweep pixel shader package
// Widths, defaults, the CORDIC pipeline word and the atan table.
// ============================================================================
package rsps_pkg;

    localparam int GRID_COLUMNS_DEFAULT = 32;
    localparam int PIXEL_COUNT_DEFAULT  = 512;

    localparam int IDX_W        = 9;
    localparam int ANGLE_W      = 16;
    localparam int COLOR_W      = 8;
    localparam int Q_W          = 12;
    localparam int CW           = 20;
    localparam int CORDIC_STEPS = 16;

    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic [ANGLE_W-1:0]   z;
        logic [ANGLE_W-1:0]   sweep;
        logic                 in_disc;
        logic                 inner;
    } cord_t;

    function automatic logic [ANGLE_W-1:0] atan_turns(input int step);
        case (step)
            0:       return 16'd8192;
            1:       return 16'd4836;
            2:       return 16'd2555;
            3:       return 16'd1297;
            4:       return 16'd651;
            5:       return 16'd326;
            6:       return 16'd163;
            7:       return 16'd81;
            8:       return 16'd41;
            9:       return 16'd20;
            10:      return 16'd10;
            11:      return 16'd5;
            12:      return 16'd3;
            13:      return 16'd1;
            14:      return 16'd1;
            default: return 16'd0;
        endcase
    endfunction

endpackage

>>> hw/rtl/rsps_front.sv
// ============================================================================
// Radar sweep pixel shader front end
// Splits the index into column and row, forms centered coordinates, tests the
// radius and pre-rotates the vector into the right half plane.
// ============================================================================
module rsps_front #(
    parameter int GRID_COLUMNS = rsps_pkg::GRID_COLUMNS_DEFAULT,
    parameter int PIXEL_COUNT  = rsps_pkg::PIXEL_COUNT_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [rsps_pkg::IDX_W-1:0]   pixel_index,
    input  logic [rsps_pkg::ANGLE_W-1:0] sweep_angle,
    output logic                         out_valid,
    input  logic                         out_ready,
    output rsps_pkg::cord_t              out_data
);

    localparam int IDX_W     = rsps_pkg::IDX_W;
    localparam int ANGLE_W   = rsps_pkg::ANGLE_W;
    localparam int Q_W       = rsps_pkg::Q_W;
    localparam int CW        = rsps_pkg::CW;
    localparam int DIV_SH    = 16;
    localparam int RECIP     = (1 << DIV_SH) / GRID_COLUMNS;
    localparam int PROD_W    = IDX_W + DIV_SH;
    localparam int COL_W     = $clog2(GRID_COLUMNS);
    localparam int ROW_MAX   = ((1 << IDX_W) - 1) / GRID_COLUMNS;
    localparam int ROW_W     = $clog2(ROW_MAX + 1);
    localparam int D2_W      = 2 * Q_W + 1;
    localparam int PRE_SHIFT = 10;
    localparam int CENTER_Q  = 31;
    localparam int OUTER_SQ  = 1156;
    localparam int INNER_SQ  = 900;
    localparam int NSTAGE    = 4;
    localparam logic [ANGLE_W-1:0] HALF_TURN = 1 << (ANGLE_W - 1);

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_in;
    logic [NSTAGE-1:0] rdy;

    logic [IDX_W-1:0]   a_idx_reg;
    logic [ROW_W-1:0]   a_row_reg;
    logic [ANGLE_W-1:0] a_sweep_reg;
    logic               a_range_reg;
    logic [ROW_W-1:0]   b_row_reg;
    logic [COL_W-1:0]   b_col_reg;
    logic [ANGLE_W-1:0] b_sweep_reg;
    logic               b_range_reg;
    logic signed [Q_W-1:0] c_xq_reg;
    logic signed [Q_W-1:0] c_yq_reg;
    logic [D2_W-1:0]       c_d2_reg;
    logic [ANGLE_W-1:0]    c_sweep_reg;
    logic                  c_range_reg;
    rsps_pkg::cord_t       d_data_reg;

    logic [PROD_W-1:0]     prod_next;
    logic [ROW_W-1:0]      a_row_next;
    logic [IDX_W:0]        rem_next;
    logic [ROW_W-1:0]      b_row_next;
    logic [COL_W-1:0]      b_col_next;
    logic signed [Q_W-1:0] xq_next;
    logic signed [Q_W-1:0] yq_next;
    logic signed [2*Q_W-1:0] sq_x;
    logic signed [2*Q_W-1:0] sq_y;
    logic [D2_W-1:0]       d2_next;
    logic signed [CW-1:0]  xe;
    logic signed [CW-1:0]  ye;
    rsps_pkg::cord_t       d_data_next;

    always_comb begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTAGE-1];
    assign out_data  = d_data_reg;
    assign v_in      = {v_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    // row estimate by reciprocal, at most one short
    assign prod_next  = PROD_W'(pixel_index) * PROD_W'(RECIP);
    assign a_row_next = ROW_W'(prod_next >> DIV_SH);

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            a_idx_reg   <= pixel_index;
            a_row_reg   <= a_row_next;
            a_sweep_reg <= sweep_angle;
            a_range_reg <= 32'(pixel_index) < 32'(PIXEL_COUNT);
        end
    end

    always_comb begin
        rem_next = {1'b0, a_idx_reg} - ((IDX_W+1)'(a_row_reg) * (IDX_W+1)'(GRID_COLUMNS));
        if (rem_next >= (IDX_W+1)'(GRID_COLUMNS)) begin
            b_row_next = a_row_reg + ROW_W'(1);
            b_col_next = COL_W'(rem_next - (IDX_W+1)'(GRID_COLUMNS));
        end else begin
            b_row_next = a_row_reg;
            b_col_next = COL_W'(rem_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            b_row_reg   <= b_row_next;
            b_col_reg   <= b_col_next;
            b_sweep_reg <= a_sweep_reg;
            b_range_reg <= a_range_reg;
        end
    end

    // odd columns sit half a row lower
    assign xq_next = $signed({{(Q_W-COL_W-1){1'b0}}, b_col_reg, 1'b0}) - Q_W'(CENTER_Q);
    assign yq_next = $signed({{(Q_W-ROW_W-2){1'b0}}, b_row_reg, 2'b00})
                   + $signed({{(Q_W-2){1'b0}}, b_col_reg[0], 1'b0})
                   - Q_W'(CENTER_Q);
    assign sq_x    = xq_next * xq_next;
    assign sq_y    = yq_next * yq_next;
    assign d2_next = D2_W'($unsigned(sq_x)) + D2_W'($unsigned(sq_y));

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            c_xq_reg    <= xq_next;
            c_yq_reg    <= yq_next;
            c_d2_reg    <= d2_next;
            c_sweep_reg <= b_sweep_reg;
            c_range_reg <= b_range_reg;
        end
    end

    always_comb begin
        xe = $signed({{(CW-Q_W){c_xq_reg[Q_W-1]}}, c_xq_reg}) <<< PRE_SHIFT;
        ye = $signed({{(CW-Q_W){c_yq_reg[Q_W-1]}}, c_yq_reg}) <<< PRE_SHIFT;
        d_data_next         = '0;
        d_data_next.sweep   = c_sweep_reg;
        d_data_next.in_disc = c_range_reg && (c_d2_reg < D2_W'(OUTER_SQ));
        d_data_next.inner   = c_d2_reg < D2_W'(INNER_SQ);
        if (d_data_next.in_disc) begin
            if (c_xq_reg[Q_W-1]) begin
                d_data_next.x = -xe;
                d_data_next.y = -ye;
                d_data_next.z = HALF_TURN;
            end else begin
                d_data_next.x = xe;
                d_data_next.y = ye;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            d_data_reg <= d_data_next;
        end
    end

endmodule

>>> hw/rtl/rsps_cordic_cell.sv
// ============================================================================
// Radar sweep pixel shader CORDIC cell
// One registered vectoring micro-rotation toward the positive x axis.
// ============================================================================
module rsps_cordic_cell #(
    parameter int STEP = 0
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_valid,
    output logic            in_ready,
    input  rsps_pkg::cord_t in_data,
    output logic            out_valid,
    input  logic            out_ready,
    output rsps_pkg::cord_t out_data
);

    localparam int CW = rsps_pkg::CW;
    localparam logic [rsps_pkg::ANGLE_W-1:0] ATAN = rsps_pkg::atan_turns(STEP);

    logic                 valid_reg;
    rsps_pkg::cord_t      data_reg;
    rsps_pkg::cord_t      data_next;
    logic signed [CW-1:0] xi;
    logic signed [CW-1:0] yi;
    logic signed [CW-1:0] dx;
    logic signed [CW-1:0] dy;

    assign xi = in_data.x;
    assign yi = in_data.y;
    assign dx = yi >>> STEP;
    assign dy = xi >>> STEP;

    always_comb begin
        data_next = in_data;
        if (!yi[CW-1]) begin
            data_next.x = xi + dx;
            data_next.y = yi - dy;
            data_next.z = in_data.z + ATAN;
        end else begin
            data_next.x = xi - dx;
            data_next.y = yi + dy;
            data_next.z = in_data.z - ATAN;
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready) begin
            data_reg <= data_next;
        end
    end

endmodule

>>> hw/rtl/rsps_shade.sv
// ============================================================================
// Radar sweep pixel shader color stage
// Turns radius and angle into fade and trail weight, then into RGB, with the
// last stage serving as the output register.
// ============================================================================
module rsps_shade (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  rsps_pkg::cord_t              in_data,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [rsps_pkg::COLOR_W-1:0] red,
    output logic [rsps_pkg::COLOR_W-1:0] green,
    output logic [rsps_pkg::COLOR_W-1:0] blue
);

    localparam int ANGLE_W  = rsps_pkg::ANGLE_W;
    localparam int COLOR_W  = rsps_pkg::COLOR_W;
    localparam int NSTAGE   = 6;
    localparam int INV_GAIN = 39797;
    localparam int PI_Q16   = 205887;
    localparam int ONE_Q16  = 65536;
    localparam int FADE_ONE = 4096;
    localparam int OUTER_Q10 = 34 * 1024;
    localparam int GF_BIAS  = 131074;
    localparam int RECIP5   = (1 << 20) / 5;

    logic [NSTAGE-1:0] v_reg;
    logic [NSTAGE-1:0] v_in;
    logic [NSTAGE-1:0] rdy;

    logic [32:0] s1_rprod_reg;
    logic [33:0] s1_pprod_reg;
    logic        s1_disc_reg;
    logic        s1_inner_reg;
    logic [16:0] s2_wt_reg;
    logic [12:0] s2_fade_reg;
    logic        s2_disc_reg;
    logic [18:0] s3_num_reg;
    logic [36:0] s3_qprod_reg;
    logic [29:0] s3_rfprod_reg;
    logic [12:0] s3_fade_reg;
    logic        s3_disc_reg;
    logic [16:0] s4_gf_reg;
    logic [12:0] s4_fade_reg;
    logic [COLOR_W-1:0] s4_red_reg;
    logic        s4_disc_reg;
    logic [29:0] s5_gprod_reg;
    logic [COLOR_W-1:0] s5_red_reg;
    logic        s5_disc_reg;
    logic [COLOR_W-1:0] red_reg;
    logic [COLOR_W-1:0] green_reg;

    logic [ANGLE_W-1:0] phi_next;
    logic [16:0]        rq_next;
    logic signed [18:0] fdiff_next;
    logic [12:0]        fade_next;
    logic [17:0]        p_next;
    logic [16:0]        wt_next;
    logic [18:0]        num_next;
    logic [16:0]        q0_next;
    logic [18:0]        rem_next;
    logic [16:0]        gf_next;
    logic [COLOR_W-1:0] red_next;
    logic [COLOR_W-1:0] green_next;

    always_comb begin
        rdy[NSTAGE-1] = !v_reg[NSTAGE-1] || out_ready;
        for (int i = NSTAGE - 2; i >= 0; i--) begin
            rdy[i] = !v_reg[i] || rdy[i+1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = v_reg[NSTAGE-1];
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = red_reg;
    assign v_in      = {v_reg[NSTAGE-2:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            for (int i = 0; i < NSTAGE; i++) begin
                if (rdy[i]) begin
                    v_reg[i] <= v_in[i];
                end
            end
        end
    end

    assign phi_next = in_data.z + in_data.sweep;

    always_ff @(posedge aclk) begin
        if (rdy[0]) begin
            s1_rprod_reg <= 33'($unsigned(in_data.x)) * 33'(INV_GAIN);
            s1_pprod_reg <= 34'(phi_next) * 34'(PI_Q16);
            s1_disc_reg  <= in_data.in_disc;
            s1_inner_reg <= in_data.inner;
        end
    end

    always_comb begin
        rq_next    = 17'((s1_rprod_reg + 33'd32768) >> 16);
        fdiff_next = 19'sd0 + 19'(OUTER_Q10) - $signed({2'b00, rq_next});
        if (s1_inner_reg || fdiff_next > 19'sd4096) begin
            fade_next = 13'(FADE_ONE);
        end else if (fdiff_next < 19'sd0) begin
            fade_next = '0;
        end else begin
            fade_next = 13'(fdiff_next);
        end
        p_next  = 18'((s1_pprod_reg + 34'd32768) >> 16);
        wt_next = (p_next >= 18'(ONE_Q16)) ? 17'd0 : 17'(18'(ONE_Q16) - p_next);
    end

    always_ff @(posedge aclk) begin
        if (rdy[1]) begin
            s2_wt_reg   <= wt_next;
            s2_fade_reg <= fade_next;
            s2_disc_reg <= s1_disc_reg;
        end
    end

    assign num_next = 19'(GF_BIAS) + 19'(s2_wt_reg) * 19'd3;

    always_ff @(posedge aclk) begin
        if (rdy[2]) begin
            s3_num_reg    <= num_next;
            s3_qprod_reg  <= 37'(num_next) * 37'(RECIP5);
            s3_rfprod_reg <= 30'(s2_wt_reg) * 30'(s2_fade_reg);
            s3_fade_reg   <= s2_fade_reg;
            s3_disc_reg   <= s2_disc_reg;
        end
    end

    // quotient by five, at most one short
    always_comb begin
        q0_next  = 17'(s3_qprod_reg >> 20);
        rem_next = s3_num_reg - 19'(q0_next) * 19'd5;
        gf_next  = (rem_next >= 19'd5) ? q0_next + 17'd1 : q0_next;
        red_next = COLOR_W'((38'(s3_rfprod_reg) * 38'd255 + 38'd134217728) >> 28);
    end

    always_ff @(posedge aclk) begin
        if (rdy[3]) begin
            s4_gf_reg   <= gf_next;
            s4_fade_reg <= s3_fade_reg;
            s4_red_reg  <= red_next;
            s4_disc_reg <= s3_disc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rdy[4]) begin
            s5_gprod_reg <= 30'(s4_gf_reg) * 30'(s4_fade_reg);
            s5_red_reg   <= s4_red_reg;
            s5_disc_reg  <= s4_disc_reg;
        end
    end

    assign green_next = COLOR_W'((38'(s5_gprod_reg) * 38'd255 + 38'd134217728) >> 28);

    // black outside the disc
    always_ff @(posedge aclk) begin
        if (rdy[5]) begin
            red_reg   <= s5_disc_reg ? s5_red_reg : '0;
            green_reg <= s5_disc_reg ? green_next : '0;
        end
    end

endmodule

>>> hw/rtl/radar_sweep_pixel_shader.sv
// ============================================================================
// Radar sweep pixel shader
// Shades one pixel of a staggered LED grid per request with a rotating
// radar trail.
// ============================================================================
// Input stream s_*: one request per pixel, pixel index plus sweep angle.
// Output stream m_*: one RGB request per input request, in input order.
// Input acceptance to m_tvalid: 4 front stages (index split, coordinates,
// radius test and pre-rotation), 16 CORDIC cells, 6 color stages.
// Throughput is one pixel per cycle; every stage is registered and the
// pipeline takes a request in every cycle while the sink keeps up.
// Every stage carries its own valid bit, so when m_tready is low the
// result holds on m_tdata, the stages behind it fill their empty slots,
// and s_tready stays high until the pipeline is full.
// Reset clears all valid bits; no request is in flight afterward.
// Index values at or past PIXEL_COUNT and pixels outside the disc give black.
// ============================================================================
module radar_sweep_pixel_shader #(
    parameter int GRID_COLUMNS = rsps_pkg::GRID_COLUMNS_DEFAULT,
    parameter int PIXEL_COUNT  = rsps_pkg::PIXEL_COUNT_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // pixel_index[8:0], sweep_angle[24:9], zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // red[7:0], green[15:8], blue[23:16]
);

    localparam int STEPS   = rsps_pkg::CORDIC_STEPS;
    localparam int IDX_W   = rsps_pkg::IDX_W;
    localparam int ANGLE_W = rsps_pkg::ANGLE_W;
    localparam int COLOR_W = rsps_pkg::COLOR_W;

    logic [STEPS:0]  chain_valid;
    logic [STEPS:0]  chain_ready;
    rsps_pkg::cord_t chain_data [0:STEPS];
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;

    rsps_front #(
        .GRID_COLUMNS (GRID_COLUMNS),
        .PIXEL_COUNT  (PIXEL_COUNT)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .pixel_index (s_tdata[IDX_W-1:0]),
        .sweep_angle (s_tdata[IDX_W+ANGLE_W-1:IDX_W]),
        .out_valid   (chain_valid[0]),
        .out_ready   (chain_ready[0]),
        .out_data    (chain_data[0])
    );

    for (genvar i = 0; i < STEPS; i++) begin : g_cell
        rsps_cordic_cell #(
            .STEP (i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    rsps_shade u_shade (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (chain_valid[STEPS]),
        .in_ready  (chain_ready[STEPS]),
        .in_data   (chain_data[STEPS]),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .red       (red),
        .green     (green),
        .blue      (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

>>> hw/rtl/rsps_checker.sv
// ============================================================================
// Radar sweep pixel shader port checker
// Watches the top-level ports for reset, flow and color relations.
// ============================================================================
`include "radar_sweep_pixel_shader_defines.svh"

module rsps_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [31:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    `RSPS_ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_tvalid, "output valid after reset")
    `RSPS_ASSERT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "stalled output changed")
    `RSPS_ASSERT(a_ready_flow, aclk, aresetn, m_tready |-> s_tready, "input stalled while sink ready")
    `RSPS_ASSERT(a_green_floor, aclk, aresetn, m_tvalid |-> m_tdata[15:8] >= m_tdata[7:0], "green below red")

endmodule

bind radar_sweep_pixel_shader rsps_checker u_rsps_checker (.*);

>>> tb/tb.sv
`timescale 1ns / 100ps
// ============================================================================
// Radar sweep pixel shader testbench
// Streams pixel requests (index plus sweep angle) into the shader and
// compares every RGB result against a cycle-free model of the
// polar-coordinate trail. The run starts with hand-picked pixels (corner,
// center, inner and outer ring, sweep wrap) and then sends random pixels.
// Both stream sides stall at random in changing mixes.
// ============================================================================
module tb;

    localparam int        IDX_W        = rsps_pkg::IDX_W;
    localparam int        ANGLE_W      = rsps_pkg::ANGLE_W;
    localparam int        COLOR_W      = rsps_pkg::COLOR_W;
    localparam int        CORDIC_STEPS = rsps_pkg::CORDIC_STEPS;
    localparam int        GRID_COLS    = 32;
    localparam int        PIXELS       = 512;
    localparam longint    CENTER_Q     = 31;
    localparam longint    OUTER_Q      = 34;
    localparam longint    OUTER_SQ     = 1156;
    localparam longint    INNER_SQ     = 900;
    localparam longint    INV_GAIN_Q16 = 39797;
    localparam longint    PI_Q16       = 205887;
    localparam longint    ONE_Q16      = 65536;
    localparam longint    FADE_ONE_Q12 = 4096;
    localparam longint    HALF_TURN    = 32768;
    localparam int        RANDOM_ITEMS = 2000;
    localparam longint    ATAN_TURNS [CORDIC_STEPS] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    typedef struct packed {
        logic [COLOR_W-1:0] blue;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] red;
    } pixel_rgb_t;

    class ShadeScoreboard;
        pixel_rgb_t rgb_q[$];
        int         errors;

        function new();
            errors = 0;
        endfunction

        function int pending();
            return rgb_q.size();
        endfunction

        static function longint unsigned scale_color(longint unsigned f16,
                                                     longint unsigned fade16);
            return (f16 * fade16 * 255 + 64'h8000_0000) >> 32;
        endfunction

        static function pixel_rgb_t shade_pixel(logic [IDX_W-1:0] idx,
                                                logic [ANGLE_W-1:0] sweep);
            longint          col, row, xq, yq, d2, x, y, z, dx, dy, rq, fade12;
            longint unsigned phi, p, wt, gf, fade16;
            pixel_rgb_t      rgb;
            rgb = '0;
            if (int'(idx) >= PIXELS) return rgb;
            col = longint'(idx) % GRID_COLS;
            row = longint'(idx) / GRID_COLS;
            xq  = 2 * col - CENTER_Q;
            yq  = 4 * row + 2 * (col & 1) - CENTER_Q;
            d2  = xq * xq + yq * yq;
            if (d2 >= OUTER_SQ) return rgb;
            x = xq * 1024;
            y = yq * 1024;
            z = 0;
            if (x < 0) begin
                x = -x;
                y = -y;
                z = HALF_TURN;
            end
            for (int i = 0; i < CORDIC_STEPS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x = x + dx;
                    y = y - dy;
                    z = z + ATAN_TURNS[i];
                end else begin
                    x = x - dx;
                    y = y + dy;
                    z = z - ATAN_TURNS[i];
                end
            end
            rq = (x * INV_GAIN_Q16 + 32768) >>> 16;
            if (d2 < INNER_SQ) begin
                fade12 = FADE_ONE_Q12;
            end else begin
                fade12 = OUTER_Q * 1024 - rq;
                if (fade12 < 0) fade12 = 0;
                if (fade12 > FADE_ONE_Q12) fade12 = FADE_ONE_Q12;
            end
            fade16 = longint'(fade12) << 4;
            phi    = (z + longint'(sweep)) & 64'hFFFF;
            p      = (phi * PI_Q16 + 32768) >> 16;
            wt     = (p >= ONE_Q16) ? 0 : ONE_Q16 - p;
            gf     = (131072 + 3 * wt + 2) / 5;
            rgb.red   = COLOR_W'(scale_color(wt, fade16));
            rgb.green = COLOR_W'(scale_color(gf, fade16));
            rgb.blue  = rgb.red;
            return rgb;
        endfunction

        task report_mismatch(string what, int got, int want);
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
            errors++;
        endtask

        function void note_request(logic [IDX_W-1:0] idx, logic [ANGLE_W-1:0] sweep);
            rgb_q.push_back(shade_pixel(idx, sweep));
        endfunction

        task check_result(logic [23:0] data);
            pixel_rgb_t got, want;
            got = data;
            if (rgb_q.size() == 0) begin
                report_mismatch("unexpected request", int'(data), 0);
            end else begin
                want = rgb_q.pop_front();
                if (got.red !== want.red)
                    report_mismatch("red", int'(got.red), int'(want.red));
                if (got.green !== want.green)
                    report_mismatch("green", int'(got.green), int'(want.green));
                if (got.blue !== want.blue)
                    report_mismatch("blue", int'(got.blue), int'(want.blue));
            end
        endtask
    endclass

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;

    int sender_idle_pct   = 19;
    int receiver_idle_pct = 80;

    ShadeScoreboard shades = new();

    radar_sweep_pixel_shader DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5ms;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        forever begin
            @(negedge aclk);
            if (aresetn && m_tvalid && m_tready) shades.check_result(m_tdata);
            @(posedge aclk);
            m_tready <= ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_pixel(input logic [IDX_W-1:0] idx, input logic [ANGLE_W-1:0] sweep);
        logic taken;
        if ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < sender_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {7'b0, sweep, idx};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        shades.note_request(idx, sweep);
    endtask

    task automatic drain_pixels();
        s_tvalid <= 1'b0;
        while (shades.pending() != 0) @(posedge aclk);
    endtask

    task automatic send_random_pixels(input int count);
        for (int n = 0; n < count; n++)
            send_pixel(IDX_W'($urandom_range(PIXELS - 1)), ANGLE_W'($urandom));
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // corner, last index, ring, outer edge, inner edge, ring, near center
        send_pixel(9'd0,   16'h0000);
        send_pixel(9'd511, 16'hFFFF);
        send_pixel(9'd255, 16'h8000);
        send_pixel(9'd92,  16'h0000);
        send_pixel(9'd222, 16'h1234);
        send_pixel(9'd190, 16'hFFFF);
        send_pixel(9'd271, 16'h0000);
        // rotate the sweep a full turn over the center pixel
        for (int k = 0; k < 16; k++)
            send_pixel(9'd271, ANGLE_W'(k * 4096));
        drain_pixels();

        send_random_pixels(RANDOM_ITEMS / 3);
        drain_pixels();

        sender_idle_pct   = 80;
        receiver_idle_pct = 19;
        send_random_pixels(RANDOM_ITEMS / 3);
        drain_pixels();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        send_random_pixels(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        drain_pixels();

        repeat (40) @(posedge aclk);
        if (shades.errors == 0 && shades.pending() == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
